[rtl/i2a_pkg.sv]
// i2a_pkg: shared types, codes and helpers for the integer-to-ASCII formatter.
// Used by i2a_divu and integer_to_ascii_formatter. No dependencies.
package i2a_pkg;

	localparam int PtrBitsDefault = 64;

	// conversion kinds
	localparam logic [2:0] OP_SDEC = 3'd0;
	localparam logic [2:0] OP_OCT  = 3'd1;
	localparam logic [2:0] OP_UDEC = 3'd2;
	localparam logic [2:0] OP_HEX  = 3'd3;
	localparam logic [2:0] OP_PTR  = 3'd4;
	localparam logic [2:0] OP_CHR  = 3'd5;

	// ceil(2^35 / 10): q = (v * Recip10) >> 35 is exact for any 32-bit v
	localparam logic [31:0] Recip10 = 32'hCCCC_CCCD;

	typedef struct packed {
		logic [2:0]  op;
		logic [63:0] value;
	} req_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} txt_t;

	typedef enum logic [1:0] {
		BASE_OCT,
		BASE_DEC,
		BASE_HEX
	} base_t;

	typedef enum logic [1:0] {
		PFX_NONE,
		PFX_MINUS,
		PFX_HEX
	} pfx_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL,
		S_DIG,
		S_PFX,
		S_OUT,
		S_NIL,
		S_CHR
	} state_t;

	// control from the sequencer to the digit unit
	typedef struct packed {
		base_t base;
	} div_ctl_t;

	function automatic logic [7:0] digit_ascii(input logic [3:0] d);
		logic [7:0] r;
		if (d < 4'd10) r = 8'h30 + {4'h0, d};
		else           r = 8'h57 + {4'h0, d};
		return r;
	endfunction

	function automatic logic [7:0] nil_ascii(input logic [2:0] i);
		logic [7:0] r;
		unique case (i)
			3'd0:    r = 8'h28; // (
			3'd1:    r = 8'h6E; // n
			3'd2:    r = 8'h69; // i
			3'd3:    r = 8'h6C; // l
			default: r = 8'h29; // )
		endcase
		return r;
	endfunction

endpackage

[rtl/i2a_divu.sv]
// i2a_divu: shared digit unit, splits a value into quotient and low digit
// for base 8, 10 or 16. Decimal uses a registered reciprocal product.
// Depends on i2a_pkg.
module i2a_divu #(
	parameter int W = 64
) (
	input  logic                clk,
	input  logic [W-1:0]        v,
	input  i2a_pkg::div_ctl_t   ctl,
	output logic [W-1:0]        q,
	output logic [3:0]          r
);

	logic [63:0] prod_q;
	logic [28:0] q10;
	logic [3:0]  q10x10;

	// product is registered: it must be taken in the cycle before q/r are used in decimal mode
	always_ff @(posedge clk) begin
		prod_q <= 64'(v[31:0]) * 64'(i2a_pkg::Recip10);
	end

	assign q10 = prod_q[63:35];
	// remainder is 0..9, so mod-16 arithmetic on the low bits is enough
	assign q10x10 = {q10[0], 3'b000} + {q10[2:0], 1'b0};

	always_comb begin
		unique case (ctl.base)
			i2a_pkg::BASE_OCT: begin
				q = v >> 3;
				r = {1'b0, v[2:0]};
			end
			i2a_pkg::BASE_DEC: begin
				q = W'(q10);
				r = v[3:0] - q10x10;
			end
			default: begin
				q = v >> 4;
				r = v[3:0];
			end
		endcase
	end

endmodule

[rtl/integer_to_ascii_formatter.sv]
// integer_to_ascii_formatter: printf-style %d %o %u %x %p %c conversion, one byte per item.
// Steps: accept in idle, then for each decimal digit a product state and a digit state, or a single
// digit state per octal/hex digit, in the shared digit unit, then one output byte per cycle unless
// txt_stall holds it (prefix, digits MSB first); %c and a null %p emit directly. One request at a time.
// Reset (arst_n low, asynchronous) returns the sequencer to idle and empties the output register.
// Depends on i2a_pkg, i2a_divu.
module integer_to_ascii_formatter #(
	parameter int PTR_BITS = i2a_pkg::PtrBitsDefault
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  i2a_pkg::req_t req,
	output logic          txt_valid,
	input  logic          txt_stall,
	output i2a_pkg::txt_t txt
);

	localparam int PtrB  = (PTR_BITS < 16) ? 16 : ((PTR_BITS > 64) ? 64 : PTR_BITS);
	localparam int ValW  = (PtrB > 32) ? PtrB : 32;
	localparam int HexD  = (PtrB + 3) / 4;
	localparam int Depth = (HexD > 11) ? HexD : 11;
	localparam int IdxW  = $clog2(Depth);
	localparam logic [ValW-1:0] PtrMask = ValW'(64'hFFFF_FFFF_FFFF_FFFF >> (64 - PtrB));

	i2a_pkg::state_t  state_q, state_d;
	i2a_pkg::base_t   base_q;
	i2a_pkg::pfx_t    pfx_q;
	logic [ValW-1:0]  val_q;
	logic [IdxW-1:0]  ndig_q;
	logic [IdxW-1:0]  ridx_q;
	logic [2:0]       sidx_q;
	logic [3:0]       dig_q [Depth];

	logic             txt_valid_q;
	i2a_pkg::txt_t    txt_q;

	logic             acc;
	logic             ld;
	logic             emit;
	i2a_pkg::txt_t    emit_txt;
	logic [31:0]      low32;
	logic [ValW-1:0]  ptr;
	logic [ValW-1:0]  q;
	logic [3:0]       rem;
	i2a_pkg::div_ctl_t div_ctl;

	assign acc   = req_valid && !req_stall;
	assign ld    = !txt_valid_q || !txt_stall;
	assign low32 = req.value[31:0];
	assign ptr   = ValW'(req.value) & PtrMask;

	assign div_ctl.base = base_q;

	i2a_divu #(.W(ValW)) u_divu (
		.clk (clk),
		.v   (val_q),
		.ctl (div_ctl),
		.q   (q),
		.r   (rem)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			i2a_pkg::S_IDLE: begin
				if (acc) begin
					priority if (req.op == i2a_pkg::OP_SDEC || req.op == i2a_pkg::OP_UDEC)
						state_d = i2a_pkg::S_MUL;
					else if (req.op == i2a_pkg::OP_OCT || req.op == i2a_pkg::OP_HEX)
						state_d = i2a_pkg::S_DIG;
					else if (req.op == i2a_pkg::OP_PTR)
						state_d = (ptr == '0) ? i2a_pkg::S_NIL : i2a_pkg::S_DIG;
					else if (req.op == i2a_pkg::OP_CHR)
						state_d = i2a_pkg::S_CHR;
					else
						state_d = i2a_pkg::S_IDLE;
				end
			end
			i2a_pkg::S_MUL: state_d = i2a_pkg::S_DIG;
			i2a_pkg::S_DIG: begin
				if (q == '0)
					state_d = (pfx_q == i2a_pkg::PFX_NONE) ? i2a_pkg::S_OUT : i2a_pkg::S_PFX;
				else
					state_d = (base_q == i2a_pkg::BASE_DEC) ? i2a_pkg::S_MUL : i2a_pkg::S_DIG;
			end
			i2a_pkg::S_PFX: begin
				if (ld && (pfx_q == i2a_pkg::PFX_MINUS || sidx_q == 3'd1))
					state_d = i2a_pkg::S_OUT;
			end
			i2a_pkg::S_OUT: begin
				if (ld && ridx_q == '0) state_d = i2a_pkg::S_IDLE;
			end
			i2a_pkg::S_NIL: begin
				if (ld && sidx_q == 3'd4) state_d = i2a_pkg::S_IDLE;
			end
			i2a_pkg::S_CHR: begin
				if (ld) state_d = i2a_pkg::S_IDLE;
			end
			default: state_d = i2a_pkg::S_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		emit          = 1'b0;
		emit_txt.ch   = 8'h00;
		emit_txt.last = 1'b0;
		unique case (state_q)
			i2a_pkg::S_PFX: begin
				emit = 1'b1;
				if (pfx_q == i2a_pkg::PFX_MINUS) emit_txt.ch = 8'h2D;
				else                              emit_txt.ch = (sidx_q == 3'd0) ? 8'h30 : 8'h78;
			end
			i2a_pkg::S_OUT: begin
				emit          = 1'b1;
				emit_txt.ch   = i2a_pkg::digit_ascii(dig_q[ridx_q]);
				emit_txt.last = (ridx_q == '0);
			end
			i2a_pkg::S_NIL: begin
				emit          = 1'b1;
				emit_txt.ch   = i2a_pkg::nil_ascii(sidx_q);
				emit_txt.last = (sidx_q == 3'd4);
			end
			i2a_pkg::S_CHR: begin
				emit          = 1'b1;
				emit_txt.ch   = val_q[7:0];
				emit_txt.last = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= i2a_pkg::S_IDLE;
			txt_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ld) txt_valid_q <= emit;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (ld && emit) txt_q <= emit_txt;
		if (acc) begin
			ndig_q <= '0;
			sidx_q <= 3'd0;
			if (req.op == i2a_pkg::OP_SDEC && low32[31]) begin
				pfx_q <= i2a_pkg::PFX_MINUS;
				val_q <= ValW'(32'(~low32 + 32'd1));
			end else if (req.op == i2a_pkg::OP_PTR) begin
				pfx_q <= i2a_pkg::PFX_HEX;
				val_q <= ptr;
			end else if (req.op == i2a_pkg::OP_CHR) begin
				pfx_q <= i2a_pkg::PFX_NONE;
				val_q <= ValW'(req.value[7:0]);
			end else begin
				pfx_q <= i2a_pkg::PFX_NONE;
				val_q <= ValW'(low32);
			end
			if (req.op == i2a_pkg::OP_OCT)
				base_q <= i2a_pkg::BASE_OCT;
			else if (req.op == i2a_pkg::OP_HEX || req.op == i2a_pkg::OP_PTR)
				base_q <= i2a_pkg::BASE_HEX;
			else
				base_q <= i2a_pkg::BASE_DEC;
		end
		if (state_q == i2a_pkg::S_DIG) begin
			dig_q[ndig_q] <= rem;
			ndig_q        <= ndig_q + 1'b1;
			val_q         <= q;
			ridx_q        <= ndig_q;
		end
		if (ld && (state_q == i2a_pkg::S_PFX || state_q == i2a_pkg::S_NIL))
			sidx_q <= sidx_q + 3'd1;
		if (ld && state_q == i2a_pkg::S_OUT)
			ridx_q <= ridx_q - 1'b1;
	end

	assign req_stall = (state_q != i2a_pkg::S_IDLE);
	assign txt_valid = txt_valid_q;
	assign txt       = txt_q;

	// decimal digits only come from a fresh product
	a_dec_after_mul: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == i2a_pkg::S_DIG && base_q == i2a_pkg::BASE_DEC)
			|-> $past(state_q) == i2a_pkg::S_MUL)
		else $error("decimal digit taken without product cycle");

	a_dec_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == i2a_pkg::S_DIG && base_q == i2a_pkg::BASE_DEC) |-> rem < 4'd10)
		else $error("decimal remainder out of range");

	a_pfx_kind: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == i2a_pkg::S_PFX |-> pfx_q != i2a_pkg::PFX_NONE)
		else $error("prefix state without prefix");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(ld && emit && emit_txt.last) |=> state_q == i2a_pkg::S_IDLE)
		else $error("final byte did not end conversion");

endmodule
